>>> rtl/core/mb_pkg.sv
package mb_pkg;

  localparam int BLOB_COUNT   = 10;
  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 200;

  localparam int CNT_W  = (BLOB_COUNT > 1) ? $clog2(BLOB_COUNT) : 1;
  localparam int NUM_W  = 25;
  localparam int MAG_W  = 25;
  localparam int SUM_W  = 26;
  localparam int DIFF_W = 10;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_ADVANCE = 2'd1;
  localparam logic [1:0] MODE_RENDER  = 2'd2;

  localparam logic [1:0] CFG_COLOR_MODE = 2'd0;
  localparam logic [1:0] CFG_ALPHA      = 2'd1;
  localparam logic [1:0] CFG_WAVE_GAIN  = 2'd2;

  localparam logic [1:0] COLOR_RGB  = 2'd0;
  localparam logic [1:0] COLOR_HUE  = 2'd1;
  localparam logic [1:0] COLOR_WAVY = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] blob_index;
    logic [8:0] coord_x;
    logic [7:0] coord_y;
    logic [5:0] blob_radius;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_word_t;

  typedef struct packed {
    logic [8:0] pos_x;
    logic [7:0] pos_y;
    logic [5:0] size;
    logic       dir_x;
    logic       dir_y;
  } blob_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> rtl/core/metaball_pixel_generator.sv
// Load and advance words take effect at the accepting edge; busy stays low.
// A render word keeps busy high while blobs rotate past the chain head one at a
// time into a shared 25-step square-root search.
// The pixel is on the result ports with done for one cycle as busy falls;
// the next word is accepted in that same cycle. The receiver cannot stall.
// Synchronous reset clears control state and direction bits and resets configuration.
module metaball_pixel_generator
  import mb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_word_t   cmd,
  output logic        done,
  output pixel_word_t pixel,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TERM  = 4'b0010,
    S_WAIT  = 4'b0100,
    S_COLOR = 4'b1000
  } state_t;

  state_t                   state;
  logic [1:0]               color_mode;
  logic [7:0]               alpha_value;
  logic signed [15:0]       wave_gain;
  logic [8:0]               cx;
  logic [7:0]               cy;
  logic [CNT_W-1:0]         cnt;
  logic signed [SUM_W-1:0]  sum;

  blob_t                    cells [BLOB_COUNT];
  logic [BLOB_COUNT-1:0]    load_sel;
  cell_ctrl_t               ctrl;
  blob_t                    load_blob;

  logic                     accept;
  logic                     wavy;
  logic [15:0]              gain_mag;
  logic [NUM_W-1:0]         num;
  logic signed [DIFF_W-1:0] dx, dy;
  logic                     root_start, root_done;
  logic [MAG_W-1:0]         mag;
  logic signed [SUM_W:0]    term, acc;
  logic [7:0]               c_red, c_green, c_blue;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign wavy   = (color_mode >= COLOR_WAVY);

  assign ctrl.load    = accept && (cmd.mode == MODE_LOAD);
  assign ctrl.advance = accept && (cmd.mode == MODE_ADVANCE);
  assign ctrl.shift   = (state == S_WAIT) && root_done;

  assign load_blob.pos_x = cmd.coord_x;
  assign load_blob.pos_y = cmd.coord_y;
  assign load_blob.size  = cmd.blob_radius;
  assign load_blob.dir_x = 1'b0;
  assign load_blob.dir_y = 1'b0;

  for (genvar i = 0; i < BLOB_COUNT; i++) begin : g_cell
    localparam int NXT = (i + 1) % BLOB_COUNT;
    assign load_sel[i] = ({1'b0, cmd.blob_index} == 5'(i));
    mb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .load_sel  (load_sel[i]),
      .load_blob (load_blob),
      .next_blob (cells[NXT]),
      .blob      (cells[i])
    );
  end

  always_comb begin
    gain_mag = wave_gain[15] ? 16'(-wave_gain) : 16'(wave_gain);
    case (color_mode)
      COLOR_RGB: num = NUM_W'({cells[0].size, 12'b0});
      COLOR_HUE: num = {13'(cells[0].size * 7'd80), 12'b0};
      default:   num = NUM_W'(gain_mag * 24'd200);
    endcase
    dx = DIFF_W'($signed({1'b0, cx})) - DIFF_W'($signed({1'b0, cells[0].pos_x}));
    dy = DIFF_W'($signed({1'b0, cy})) - DIFF_W'($signed({1'b0, cells[0].pos_y}));
  end

  assign root_start = (state == S_TERM);

  mb_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .dx    (dx),
    .dy    (dy),
    .num   (num),
    .done  (root_done),
    .mag   (mag)
  );

  always_comb begin
    term = (wavy && wave_gain[15]) ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
    acc  = {sum[SUM_W-1], sum} + term;
  end

  mb_color u_color (
    .sum      (sum),
    .hue_mode (color_mode != COLOR_RGB),
    .red      (c_red),
    .green    (c_green),
    .blue     (c_blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode  <= COLOR_RGB;
      alpha_value <= 8'd255;
      wave_gain   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_COLOR_MODE: color_mode  <= cfg_data[1:0];
        CFG_ALPHA:      alpha_value <= cfg_data[7:0];
        CFG_WAVE_GAIN:  wave_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (accept && cmd.mode == MODE_RENDER) state <= S_TERM;
        S_TERM: state <= S_WAIT;
        S_WAIT: begin
          if (root_done)
            state <= (cnt == CNT_W'(BLOB_COUNT - 1)) ? S_COLOR : S_TERM;
        end
        S_COLOR: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cx  <= cmd.coord_x;
        cy  <= cmd.coord_y;
        cnt <= '0;
        sum <= wavy ? SUM_W'({10'(cmd.coord_x) + 10'(cmd.coord_y), 12'b0}) : '0;
      end
      S_WAIT: begin
        if (root_done) begin
          cnt <= cnt + 1'b1;
          if (acc > (SUM_W + 1)'(33554431))
            sum <= SUM_W'(33554431);
          else if (acc < -(SUM_W + 1)'(33554432))
            sum <= {1'b1, {(SUM_W - 1){1'b0}}};
          else
            sum <= acc[SUM_W-1:0];
        end
      end
      S_COLOR: begin
        pixel.red   <= c_red;
        pixel.green <= c_green;
        pixel.blue  <= c_blue;
        pixel.alpha <= alpha_value;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/mb_cell.sv
module mb_cell
  import mb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       load_sel,
  input  blob_t      load_blob,
  input  blob_t      next_blob,
  output blob_t      blob
);

  logic signed [11:0] x, y, r;
  logic               fx, fy;
  blob_t              blob_next;

  always_comb begin
    r  = 12'(blob.size);
    x  = blob.dir_x ? 12'(blob.pos_x) - 12'sd1 : 12'(blob.pos_x) + 12'sd1;
    y  = blob.dir_y ? 12'(blob.pos_y) - 12'sd1 : 12'(blob.pos_y) + 12'sd1;
    fx = blob.dir_x;
    fy = blob.dir_y;
    if (x + r > 12'(FRAME_WIDTH - 1)) begin
      x  = 12'(FRAME_WIDTH - 1) - r;
      fx = ~fx;
    end
    if (x - r < 12'sd0) begin
      x  = r;
      fx = ~fx;
    end
    if (y + r > 12'(FRAME_HEIGHT - 1)) begin
      y  = 12'(FRAME_HEIGHT) - r;
      fy = ~fy;
    end
    if (y - r < 12'sd0) begin
      y  = r;
      fy = ~fy;
    end

    blob_next = blob;
    if (ctrl.load && load_sel) begin
      blob_next       = load_blob;
      blob_next.dir_x = 1'b0;
      blob_next.dir_y = 1'b0;
    end else if (ctrl.advance) begin
      blob_next.pos_x = x[8:0];
      blob_next.pos_y = y[7:0];
      blob_next.dir_x = fx;
      blob_next.dir_y = fy;
    end else if (ctrl.shift) begin
      blob_next = next_blob;
    end
  end

  always_ff @(posedge clk) begin
    blob.pos_x <= blob_next.pos_x;
    blob.pos_y <= blob_next.pos_y;
    blob.size  <= blob_next.size;
    if (rst) begin
      blob.dir_x <= 1'b0;
      blob.dir_y <= 1'b0;
    end else begin
      blob.dir_x <= blob_next.dir_x;
      blob.dir_y <= blob_next.dir_y;
    end
  end

endmodule

>>> rtl/core/mb_root.sv
module mb_root
  import mb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] dx,
  input  logic signed [DIFF_W-1:0] dy,
  input  logic [NUM_W-1:0]         num,
  output logic                     done,
  output logic [MAG_W-1:0]         mag
);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_SQ   = 4'b0010,
    R_PREP = 4'b0100,
    R_RUN  = 4'b1000
  } rstate_t;

  rstate_t                  state;
  logic signed [DIFF_W-1:0] dxs, dys;
  logic [NUM_W-1:0]         nums;
  logic [19:0]              sqx, sqy;
  logic [49:0]              nn;
  logic [49:0]              rem;
  logic [50:0]              acc_a;
  logic [67:0]              acc_b;
  logic [MAG_W-1:0]         m;
  logic [4:0]               k;
  logic [67:0]              trial;
  logic [67:0]              a_sum;
  logic [20:0]              dsum;

  assign trial = 68'(acc_a) + acc_b;
  assign a_sum = 68'(acc_a >> 1) + acc_b;
  assign dsum  = 21'(sqx) + 21'(sqy);
  assign mag   = (nums == '0) ? '0 : m;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        R_IDLE: if (start) state <= R_SQ;
        R_SQ:   state <= R_PREP;
        R_PREP: state <= R_RUN;
        R_RUN: begin
          if (k == 5'd0) begin
            state <= R_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      R_IDLE: begin
        if (start) begin
          dxs  <= dx;
          dys  <= dy;
          nums <= num;
        end
      end
      R_SQ: begin
        sqx <= 20'(dxs * dxs);
        sqy <= 20'(dys * dys);
        nn  <= 50'(nums) * 50'(nums);
      end
      R_PREP: begin
        rem   <= nn;
        acc_a <= '0;
        acc_b <= {dsum[19:0], 48'b0};
        m     <= '0;
        k     <= 5'(MAG_W - 1);
      end
      R_RUN: begin
        if (trial <= 68'(rem)) begin
          rem   <= rem - trial[49:0];
          acc_a <= a_sum[50:0];
          m     <= m | (MAG_W'(1) << k);
        end else begin
          acc_a <= acc_a >> 1;
        end
        acc_b <= acc_b >> 2;
        k     <= k - 5'd1;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/mb_color.sv
module mb_color
  import mb_pkg::*;
(
  input  logic signed [SUM_W-1:0] sum,
  input  logic                    hue_mode,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue
);

  localparam logic [21:0] HUE_UNIT = 22'd245760;
  localparam logic [21:0] HUE_FULL = 22'd1474560;

  function automatic logic [7:0] hue_chan(input logic [21:0] h, input logic [2:0] n);
    logic [21:0]        v, u;
    logic signed [22:0] c0, c, us, unit_s;
    logic [21:0]        x;
    logic [26:0]        p;
    v = 22'(n) * HUE_UNIT + h;
    u = (v >= HUE_FULL) ? v - HUE_FULL : v;
    us     = $signed({1'b0, u});
    unit_s = $signed({1'b0, HUE_UNIT});
    c0 = 23'(4 * HUE_UNIT) - 23'(u);
    c  = (us < c0) ? us : c0;
    if (c > unit_s) c = unit_s;
    if (c < 23'sd0) c = 23'sd0;
    x = HUE_UNIT - 22'(c);
    p = 27'(x) * 27'd17;
    return p[21:14];
  endfunction

  logic [12:0] k;
  logic [22:0] prod;
  logic [9:0]  f1;
  logic [8:0]  f2;
  logic [7:0]  rgb_red;
  logic [31:0] bl;
  logic [21:0] h;

  always_comb begin
    k    = sum[24:12];
    prod = 23'(k) * 23'd1000;
    f1   = 10'(prod[7:0]) + 10'(prod[15:8]) + 10'(prod[22:16]);
    f2   = 9'(f1[7:0]) + 9'(f1[9:8]);
    rgb_red = (f2 >= 9'd255) ? 8'(f2 - 9'd255) : f2[7:0];
    bl   = 32'd131072 + 32'(sum[24:0]) * 32'd50;

    if (sum < SUM_W'(20 * 4096))
      h = 22'(20 * 4096);
    else if (sum > SUM_W'(360 * 4096))
      h = 22'(360 * 4096);
    else
      h = 22'(sum);

    if (hue_mode) begin
      red   = hue_chan(h, 3'd5);
      green = hue_chan(h, 3'd3);
      blue  = hue_chan(h, 3'd1);
    end else begin
      red   = rgb_red;
      green = 8'd255 - rgb_red;
      blue  = bl[19:12];
    end
  end

endmodule

>>> rtl/core/mb_checker.sv
module mb_checker
  import mb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input cmd_word_t   cmd,
  input logic        done
);

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a render in flight");

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held two cycles");

  a_quick_words: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.mode != MODE_RENDER) |=> !busy)
    else $error("non-render word made the block busy");

  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("render finished without a pixel");

endmodule

bind metaball_pixel_generator mb_checker u_mb_checker (.*);

>>> sim/metaball_pixel_generator_tb.sv
`timescale 1ns / 100ps

module metaball_pixel_generator_tb;
  import mb_pkg::*;

  localparam longint SAT_HI = 64'sd33554431;
  localparam longint SAT_LO = -64'sd33554432;
  localparam longint HUE_STEP = 64'sd245760;
  localparam longint HUE_WRAP = 64'sd1474560;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  cmd_word_t   cmd;
  logic        done;
  pixel_word_t pixel;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  metaball_pixel_generator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .pixel(pixel), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of blob table and registers
  logic [8:0]   bx [BLOB_COUNT];
  logic [7:0]   by [BLOB_COUNT];
  logic [5:0]   bsize [BLOB_COUNT];
  logic         bdx [BLOB_COUNT];
  logic         bdy [BLOB_COUNT];
  logic [1:0]   cur_color;
  logic [7:0]   cur_alpha;
  logic [15:0]  cur_gain;

  cmd_word_t    pending_cmds[$];
  pixel_word_t  expected_pixels[$];
  int           sender_idle_pct;
  int           mismatches;
  int           pixels_checked;
  int           words_sent;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint unsigned root_down(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] hue_level(longint h, longint ofs);
    longint u;
    longint c;
    u = (ofs * HUE_STEP + h) % HUE_WRAP;
    c = 4 * HUE_STEP - u;
    if (u < c) c = u;
    if (c > HUE_STEP) c = HUE_STEP;
    if (c < 0) c = 0;
    return 8'(((HUE_STEP - c) * 255) / HUE_STEP);
  endfunction

  function automatic pixel_word_t shade_pixel(cmd_word_t w);
    pixel_word_t p;
    longint sum;
    longint dx;
    longint dy;
    longint unsigned d2;
    longint unsigned num;
    longint unsigned mag;
    longint g;
    longint unsigned k;
    longint h;
    bit neg;
    sum = (cur_color >= 2) ? (longint'(w.coord_x) + longint'(w.coord_y)) * 4096 : 0;
    for (int i = 0; i < BLOB_COUNT; i++) begin
      dx = longint'(w.coord_x) - longint'(bx[i]);
      dy = longint'(w.coord_y) - longint'(by[i]);
      d2 = dx * dx + dy * dy;
      neg = 0;
      if (cur_color == COLOR_RGB) num = longint'(bsize[i]) * 4096;
      else if (cur_color == COLOR_HUE) num = longint'(bsize[i]) * 80 * 4096;
      else begin
        g = longint'($signed(cur_gain));
        neg = g < 0;
        num = (neg ? -g : g) * 200;
      end
      if (num == 0) mag = 0;
      else if (d2 == 0) mag = SAT_HI;
      else begin
        mag = root_down((num * num) / d2);
        if (mag > SAT_HI) mag = SAT_HI;
      end
      sum = sum + (neg ? -longint'(mag) : longint'(mag));
      if (sum > SAT_HI) sum = SAT_HI;
      if (sum < SAT_LO) sum = SAT_LO;
    end
    if (cur_color == COLOR_RGB) begin
      k = longint'(sum) >>> 12;
      p.red = 8'((k * 1000) % 255);
      p.green = 8'd255 - p.red;
      p.blue = 8'((32 * 4096 + sum * 50) >>> 12);
    end else begin
      h = sum;
      if (h < 20 * 4096) h = 20 * 4096;
      if (h > 360 * 4096) h = 360 * 4096;
      p.red = hue_level(h, 5);
      p.green = hue_level(h, 3);
      p.blue = hue_level(h, 1);
    end
    p.alpha = cur_alpha;
    return p;
  endfunction

  function automatic void step_blobs();
    int r, x, y;
    for (int i = 0; i < BLOB_COUNT; i++) begin
      r = bsize[i];
      x = int'(bx[i]) + (bdx[i] ? -1 : 1);
      y = int'(by[i]) + (bdy[i] ? -1 : 1);
      if (x + r > FRAME_WIDTH - 1) begin
        x = FRAME_WIDTH - 1 - r;
        bdx[i] = ~bdx[i];
      end
      if (x - r < 0) begin
        x = r;
        bdx[i] = ~bdx[i];
      end
      if (y + r > FRAME_HEIGHT - 1) begin
        y = FRAME_HEIGHT - r;
        bdy[i] = ~bdy[i];
      end
      if (y - r < 0) begin
        y = r;
        bdy[i] = ~bdy[i];
      end
      bx[i] = 9'(x);
      by[i] = 8'(y);
    end
  endfunction

  function automatic void apply_word(cmd_word_t w);
    if (w.mode == MODE_LOAD) begin
      if (w.blob_index < BLOB_COUNT) begin
        bx[w.blob_index] = w.coord_x;
        by[w.blob_index] = w.coord_y;
        bsize[w.blob_index] = w.blob_radius;
        bdx[w.blob_index] = 1'b0;
        bdy[w.blob_index] = 1'b0;
      end
    end else if (w.mode == MODE_ADVANCE) begin
      step_blobs();
    end else if (w.mode == MODE_RENDER) begin
      expected_pixels.push_back(shade_pixel(w));
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cmd <= '0;
    end else begin
      if (start && !busy) begin
        apply_word(cmd);
        void'(pending_cmds.pop_front());
        words_sent++;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 &&
            $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          cmd <= pending_cmds[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h", pixel);
      end else begin
        pixel_word_t e;
        e = expected_pixels.pop_front();
        pixels_checked++;
        if (pixel.red !== e.red || pixel.green !== e.green ||
            pixel.blue !== e.blue || pixel.alpha !== e.alpha) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
                     e.red, e.green, e.blue, e.alpha,
                     pixel.red, pixel.green, pixel.blue, pixel.alpha);
        end
      end
    end
  end

  function automatic cmd_word_t make_word(logic [1:0] m, logic [3:0] idx,
                                          logic [8:0] x, logic [7:0] y, logic [5:0] r);
    cmd_word_t w;
    w.mode = m;
    w.blob_index = idx;
    w.coord_x = x;
    w.coord_y = y;
    w.blob_radius = r;
    return w;
  endfunction

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || expected_pixels.size() != 0 || start || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_COLOR_MODE) cur_color = val[1:0];
    else if (idx == CFG_ALPHA) cur_alpha = val[7:0];
    else if (idx == CFG_WAVE_GAIN) cur_gain = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 15)
        pending_cmds.push_back(make_word(MODE_LOAD, 4'($urandom_range(9)),
          9'($urandom), 8'($urandom), 6'($urandom)));
      else if (pick < 30)
        pending_cmds.push_back(make_word(MODE_ADVANCE, 4'($urandom), 9'($urandom),
          8'($urandom), 6'($urandom)));
      else if (pick < 35)
        pending_cmds.push_back(make_word(MODE_LOAD, 4'($urandom_range(15, 10)),
          9'($urandom), 8'($urandom), 6'($urandom)));
      else if (pick < 40)
        pending_cmds.push_back(make_word(2'd3, 4'($urandom), 9'($urandom),
          8'($urandom), 6'($urandom)));
      else if (pick < 50)
        pending_cmds.push_back(make_word(MODE_RENDER, 4'($urandom),
          bx[$urandom_range(BLOB_COUNT - 1)], by[$urandom_range(BLOB_COUNT - 1)],
          6'($urandom)));
      else
        pending_cmds.push_back(make_word(MODE_RENDER, 4'($urandom), 9'($urandom),
          8'($urandom), 6'($urandom)));
    end
  endtask

  int idle_by_phase [6] = '{0, 66, 0, 29, 66, 0};
  logic [1:0]  color_by_phase [6] = '{COLOR_RGB, COLOR_HUE, COLOR_WAVY, 2'd3, COLOR_WAVY, COLOR_RGB};
  logic [15:0] alpha_by_phase [6] = '{16'd255, 16'd0, 16'd128, 16'd17, 16'hFFAA, 16'd200};
  logic [15:0] gain_by_phase [6] = '{16'd0, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 16'd1};

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_color = COLOR_RGB;
    cur_alpha = 8'd255;
    cur_gain = '0;
    mismatches = 0;
    pixels_checked = 0;
    words_sent = 0;
    sender_idle_pct = 0;
    for (int i = 0; i < BLOB_COUNT; i++) begin
      bdx[i] = 1'b0;
      bdy[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every blob loaded first so nothing reads an unwritten entry
    pending_cmds.push_back(make_word(MODE_LOAD, 4'd0, 9'd0, 8'd0, 6'd0));
    pending_cmds.push_back(make_word(MODE_LOAD, 4'd1, 9'd320, 8'd200, 6'd63));
    pending_cmds.push_back(make_word(MODE_LOAD, 4'd2, 9'd511, 8'd255, 6'd63));
    pending_cmds.push_back(make_word(MODE_LOAD, 4'd3, 9'd0, 8'd255, 6'd1));
    pending_cmds.push_back(make_word(MODE_LOAD, 4'd4, 9'd319, 8'd0, 6'd42));
    pending_cmds.push_back(make_word(MODE_LOAD, 4'd5, 9'd160, 8'd100, 6'd21));
    pending_cmds.push_back(make_word(MODE_LOAD, 4'd6, 9'd63, 8'd199, 6'd10));
    pending_cmds.push_back(make_word(MODE_LOAD, 4'd7, 9'd256, 8'd128, 6'd32));
    pending_cmds.push_back(make_word(MODE_LOAD, 4'd8, 9'd100, 8'd50, 6'd5));
    pending_cmds.push_back(make_word(MODE_LOAD, 4'd9, 9'd300, 8'd10, 6'd60));
    pending_cmds.push_back(make_word(MODE_LOAD, 4'd15, 9'd1, 8'd1, 6'd1));
    pending_cmds.push_back(make_word(2'd3, 4'd0, 9'd511, 8'd255, 6'd63));
    pending_cmds.push_back(make_word(MODE_RENDER, 4'd0, 9'd160, 8'd100, 6'd0));
    pending_cmds.push_back(make_word(MODE_RENDER, 4'd0, 9'd0, 8'd0, 6'd0));
    pending_cmds.push_back(make_word(MODE_RENDER, 4'd0, 9'd511, 8'd255, 6'd0));
    pending_cmds.push_back(make_word(MODE_RENDER, 4'd0, 9'd1, 8'd1, 6'd0));
    pending_cmds.push_back(make_word(MODE_ADVANCE, 4'd0, 9'd0, 8'd0, 6'd0));
    pending_cmds.push_back(make_word(MODE_ADVANCE, 4'd0, 9'd0, 8'd0, 6'd0));
    pending_cmds.push_back(make_word(MODE_RENDER, 4'd0, 9'd319, 8'd199, 6'd0));
    pending_cmds.push_back(make_word(MODE_ADVANCE, 4'd0, 9'd0, 8'd0, 6'd0));
    pending_cmds.push_back(make_word(MODE_RENDER, 4'd0, 9'd170, 8'd90, 6'd0));
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_COLOR_MODE, {14'd0, color_by_phase[ph]});
      write_reg(CFG_ALPHA, alpha_by_phase[ph]);
      write_reg(CFG_WAVE_GAIN, gain_by_phase[ph]);
      sender_idle_pct = idle_by_phase[ph];
      // zero-distance pixel at blob 0 under each setting
      pending_cmds.push_back(make_word(MODE_RENDER, 4'd0, bx[0], by[0], 6'd0));
      queue_random(220);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d command words over 6 register settings; %0d pixels checked.",
             words_sent, pixels_checked);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
